FILE: hw/rtl/tqhs_pkg.sv
`timescale 1ns / 1ps

package tqhs_pkg;

    // Fixed field widths of the stream payloads.
    localparam int RES_W      = 6;
    localparam int SUB_OUT_W  = 6;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;

    // Item codes carried on s_axis_tuser.
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FRAME  = 1'b1;

    // Input tdata layout, lowest bit first: resource_index, is_write,
    // has_access, pass_queue, then zero padding.
    typedef struct packed {
        logic [6:0]       pad;
        logic             pass_queue;
        logic             has_access;
        logic             is_write;
        logic [RES_W-1:0] resource_index;
    } s_data_t;

    // Output tdata layout, lowest bit first: opened_new, submission_index,
    // queue_used, wait_valid, wait_index, overflow.
    typedef struct packed {
        logic                 overflow;
        logic [SUB_OUT_W-1:0] wait_index;
        logic                 wait_valid;
        logic                 queue_used;
        logic [SUB_OUT_W-1:0] submission_index;
        logic                 opened_new;
    } m_data_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic             op;
        logic [RES_W-1:0] res;
        logic             wr;
        logic             acc;
        logic             pq;
        logic             last;
    } item_t;

endpackage

FILE: hw/rtl/tqhs_front.sv
`timescale 1ns / 1ps

module tqhs_front #(
    parameter int RESOURCE_COUNT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic                 s_last,
    input  tqhs_pkg::s_data_t    s_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output tqhs_pkg::item_t      q_item
);

    tqhs_pkg::item_t fifo_reg [2];
    logic            wp_reg, wp_next;
    logic            rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;
    tqhs_pkg::item_t cls;
    logic            push;
    logic            pop;

    // Classify the beat: an access counts only when declared and in range.
    always_comb begin
        cls.op   = s_op;
        cls.res  = s_data.resource_index;
        cls.wr   = s_data.is_write;
        cls.acc  = s_data.has_access &&
                   ({26'd0, s_data.resource_index} < 32'(RESOURCE_COUNT));
        cls.pq   = s_data.pass_queue;
        cls.last = s_last;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_item  = fifo_reg[rp_reg];

    // Two-entry queue pointers.
    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wp_reg] <= cls;
        end
    end

endmodule

FILE: hw/rtl/tqhs_back.sv
`timescale 1ns / 1ps

module tqhs_back #(
    parameter int RESOURCE_COUNT      = 64,
    parameter int SUBMISSION_CAPACITY = 64,
    parameter int ACCESSES_PER_PASS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 async_enable,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  tqhs_pkg::item_t      q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tqhs_pkg::m_data_t    m_data
);

    localparam int RW = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;
    localparam int SW = (SUBMISSION_CAPACITY > 1) ? $clog2(SUBMISSION_CAPACITY) : 1;
    localparam int PW = (ACCESSES_PER_PASS > 1) ? $clog2(ACCESSES_PER_PASS) : 1;
    localparam int CW = $clog2(ACCESSES_PER_PASS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOK   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_UPD    = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [RW-1:0] pend_res_reg [ACCESSES_PER_PASS];
    logic          pend_wr_reg  [ACCESSES_PER_PASS];
    logic          pend_we;

    logic          q_reg, q_next;
    logic          need_v_reg, need_v_next;
    logic [SW-1:0] need_idx_reg, need_idx_next;
    logic          tail_v_reg, tail_v_next;
    logic [SW-1:0] tail_idx_reg, tail_idx_next;
    logic          tail_q_reg, tail_q_next;
    logic          twait_v_reg, twait_v_next;
    logic [SW-1:0] twait_idx_reg, twait_idx_next;
    logic          qlast_reg, qlast_next;
    logic          ovf_reg, ovf_next;

    logic          m_valid_reg, m_valid_next;
    tqhs_pkg::m_data_t m_data_reg, m_data_next;

    // Table storage: last writer with its queue, last reader per queue.
    logic [SW:0]   wr_mem  [RESOURCE_COUNT];
    logic [SW-1:0] rd0_mem [RESOURCE_COUNT];
    logic [SW-1:0] rd1_mem [RESOURCE_COUNT];
    logic [RESOURCE_COUNT-1:0] wr_vld_reg, wr_vld_next;
    logic [RESOURCE_COUNT-1:0] rd0_vld_reg, rd0_vld_next;
    logic [RESOURCE_COUNT-1:0] rd1_vld_reg, rd1_vld_next;

    // Lookup stage registers.
    logic          lk_v_reg, lk_v_next;
    logic          lk_wr_reg, lk_wr_next;
    logic          lkw_v_reg, lkr0_v_reg, lkr1_v_reg;
    logic [SW:0]   lkw_reg;
    logic [SW-1:0] lkr0_reg, lkr1_reg;

    logic [RW-1:0] t_addr;
    logic [PW-1:0] i_sel;
    logic          tw_en, tr_en;
    logic [SW-1:0] cur;
    logic          wq, lkr_v;
    logic [SW-1:0] lkr_idx;
    logic          same, covered, opened;
    logic [SW-1:0] new_idx;
    logic          issue;

    assign i_sel   = i_reg[PW-1:0];
    assign t_addr  = pend_res_reg[i_sel];
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The other queue's reader and the writer's current queue.
    always_comb begin
        lkr_v   = q_reg ? lkr0_v_reg : lkr1_v_reg;
        lkr_idx = q_reg ? lkr0_reg : lkr1_reg;
        wq      = (lkw_reg[SW-1:0] == SW'(SUBMISSION_CAPACITY - 1)) ?
                  qlast_reg : lkw_reg[SW];
    end

    // Join-or-open decision for the closing item.
    always_comb begin
        same    = tail_v_reg && (tail_q_reg == q_reg);
        covered = same && (!need_v_reg ||
                  (twait_v_reg && (need_idx_reg <= twait_idx_reg)));
        opened  = !covered;
        if (!tail_v_reg) begin
            new_idx = '0;
        end else if (tail_idx_reg < SW'(SUBMISSION_CAPACITY - 1)) begin
            new_idx = tail_idx_reg + SW'(1);
        end else begin
            new_idx = SW'(SUBMISSION_CAPACITY - 1);
        end
        cur = opened ? new_idx : tail_idx_reg;
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        q_next         = q_reg;
        need_v_next    = need_v_reg;
        need_idx_next  = need_idx_reg;
        tail_v_next    = tail_v_reg;
        tail_idx_next  = tail_idx_reg;
        tail_q_next    = tail_q_reg;
        twait_v_next   = twait_v_reg;
        twait_idx_next = twait_idx_reg;
        qlast_next     = qlast_reg;
        ovf_next       = ovf_reg;
        wr_vld_next    = wr_vld_reg;
        rd0_vld_next   = rd0_vld_reg;
        rd1_vld_next   = rd1_vld_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        lk_v_next      = 1'b0;
        lk_wr_next     = pend_wr_reg[i_sel];
        q_pop          = 1'b0;
        pend_we        = 1'b0;
        tw_en          = 1'b0;
        tr_en          = 1'b0;
        issue          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    if (q_item.op == tqhs_pkg::OP_FRAME) begin
                        cnt_next     = '0;
                        tail_v_next  = 1'b0;
                        tail_q_next  = 1'b0;
                        twait_v_next = 1'b0;
                        need_v_next  = 1'b0;
                        ovf_next     = 1'b0;
                        wr_vld_next  = '0;
                        rd0_vld_next = '0;
                        rd1_vld_next = '0;
                    end else begin
                        if (q_item.acc && (cnt_reg < CW'(ACCESSES_PER_PASS))) begin
                            pend_we  = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        if (q_item.last) begin
                            q_next      = async_enable ? q_item.pq : 1'b0;
                            need_v_next = 1'b0;
                            i_next      = '0;
                            state_next  = ST_LOOK;
                        end
                    end
                end
            end
            ST_LOOK: begin
                // Issue one table read a cycle; fold in the previous read.
                issue = (i_reg < cnt_reg);
                if (issue) begin
                    lk_v_next = 1'b1;
                    i_next    = i_reg + CW'(1);
                end
                if (lk_v_reg && lkw_v_reg && (wq != q_reg) &&
                    (!need_v_reg || (lkw_reg[SW-1:0] > need_idx_reg))) begin
                    need_v_next   = 1'b1;
                    need_idx_next = lkw_reg[SW-1:0];
                end
                if (lk_v_reg && lk_wr_reg && lkr_v &&
                    (!need_v_next || (lkr_idx > need_idx_next))) begin
                    need_v_next   = 1'b1;
                    need_idx_next = lkr_idx;
                end
                if (!issue && !lk_v_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!m_valid_reg || m_ready) begin
                    if (opened) begin
                        tail_v_next    = 1'b1;
                        tail_idx_next  = new_idx;
                        tail_q_next    = q_reg;
                        twait_v_next   = need_v_reg;
                        twait_idx_next = need_idx_reg;
                        if (new_idx == SW'(SUBMISSION_CAPACITY - 1)) begin
                            qlast_next = q_reg;
                        end
                        if (tail_v_reg &&
                            !(tail_idx_reg < SW'(SUBMISSION_CAPACITY - 1))) begin
                            ovf_next = 1'b1;
                        end
                    end
                    m_valid_next                 = 1'b1;
                    m_data_next.opened_new       = opened;
                    m_data_next.submission_index = tqhs_pkg::SUB_OUT_W'(cur);
                    m_data_next.queue_used       = q_reg;
                    m_data_next.wait_valid       = opened && need_v_reg;
                    m_data_next.wait_index       = (opened && need_v_reg) ?
                        tqhs_pkg::SUB_OUT_W'(need_idx_reg) : '0;
                    m_data_next.overflow         = ovf_next;
                    i_next     = '0;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                // Record the pass's submission for each buffered access.
                if (i_reg < cnt_reg) begin
                    if (pend_wr_reg[i_sel]) begin
                        tw_en               = 1'b1;
                        wr_vld_next[t_addr] = 1'b1;
                    end else begin
                        tr_en = 1'b1;
                        if (q_reg) begin
                            rd1_vld_next[t_addr] = 1'b1;
                        end else begin
                            rd0_vld_next[t_addr] = 1'b1;
                        end
                    end
                    i_next = i_reg + CW'(1);
                end else begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            i_reg       <= '0;
            need_v_reg  <= 1'b0;
            tail_v_reg  <= 1'b0;
            tail_q_reg  <= 1'b0;
            twait_v_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            lk_v_reg    <= 1'b0;
            wr_vld_reg  <= '0;
            rd0_vld_reg <= '0;
            rd1_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            i_reg       <= i_next;
            need_v_reg  <= need_v_next;
            tail_v_reg  <= tail_v_next;
            tail_q_reg  <= tail_q_next;
            twait_v_reg <= twait_v_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            lk_v_reg    <= lk_v_next;
            wr_vld_reg  <= wr_vld_next;
            rd0_vld_reg <= rd0_vld_next;
            rd1_vld_reg <= rd1_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        q_reg         <= q_next;
        need_idx_reg  <= need_idx_next;
        tail_idx_reg  <= tail_idx_next;
        twait_idx_reg <= twait_idx_next;
        qlast_reg     <= qlast_next;
        m_data_reg    <= m_data_next;
        lk_wr_reg     <= lk_wr_next;
        lkw_v_reg     <= wr_vld_reg[t_addr];
        lkr0_v_reg    <= rd0_vld_reg[t_addr];
        lkr1_v_reg    <= rd1_vld_reg[t_addr];
        if (pend_we) begin
            pend_res_reg[cnt_reg[PW-1:0]] <= RW'(q_item.res);
            pend_wr_reg[cnt_reg[PW-1:0]]  <= q_item.wr;
        end
    end

    // Table memories: one registered read and one write a cycle.
    always_ff @(posedge aclk) begin
        lkw_reg  <= wr_mem[t_addr];
        lkr0_reg <= rd0_mem[t_addr];
        lkr1_reg <= rd1_mem[t_addr];
        if (tw_en) begin
            wr_mem[t_addr] <= {q_reg, cur};
        end
        if (tr_en && !q_reg) begin
            rd0_mem[t_addr] <= cur;
        end
        if (tr_en && q_reg) begin
            rd1_mem[t_addr] <= cur;
        end
    end

endmodule

FILE: hw/rtl/two_queue_hazard_scheduler_top.sv
`timescale 1ns / 1ps

// Channel   Ports                      Beat contents
// s_axis    tvalid tready tdata tuser  access or frame start, tlast closes a pass
//           tlast
// m_axis    tvalid tready tdata        one result for each pass
// config    async_enable_we/_wdata     async_enable, a registered bit
//
// The back end takes a non-closing access from the queue while idle. A closing item
// runs a hazard lookup, one table read a cycle over its buffered accesses, then a
// decision, which waits while the result register still holds a beat, and then
// the table update, one table write a cycle.
// Reset is synchronous and active low; it clears all tables at once.
// A two-entry queue lets the input side keep taking beats while the back end
// works, and the result register holds a beat while m_axis_tready is low.

module two_queue_hazard_scheduler_top #(
    parameter int RESOURCE_COUNT      = 64,
    parameter int SUBMISSION_CAPACITY = 64,
    parameter int ACCESSES_PER_PASS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        async_enable_we,
    input  logic        async_enable_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // resource_index[5:0], is_write[6], has_access[7], pass_queue[8], zeros
    input  logic [15:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // opened_new[0], submission_index[6:1], queue_used[7], wait_valid[8],
    // wait_index[14:9], overflow[15]
    output logic [15:0] m_axis_tdata
);

    logic              async_enable_reg;
    logic              q_valid;
    logic              q_pop;
    tqhs_pkg::item_t   q_item;
    tqhs_pkg::m_data_t m_data;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            async_enable_reg <= 1'b0;
        end else if (async_enable_we) begin
            async_enable_reg <= async_enable_wdata;
        end
    end

    tqhs_front #(
        .RESOURCE_COUNT(RESOURCE_COUNT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_op    (s_axis_tuser),
        .s_last  (s_axis_tlast),
        .s_data  (tqhs_pkg::s_data_t'(s_axis_tdata)),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    tqhs_back #(
        .RESOURCE_COUNT      (RESOURCE_COUNT),
        .SUBMISSION_CAPACITY (SUBMISSION_CAPACITY),
        .ACCESSES_PER_PASS   (ACCESSES_PER_PASS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .async_enable (async_enable_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_data       (m_data)
    );

    assign m_axis_tdata = m_data;

endmodule
